FILE: sv/lbpm_pkg.sv
// ----------------------------------------------------------------------------
// lbpm_pkg
// Shared constants, codes and types of the LRU buffer-pool manager.
// ----------------------------------------------------------------------------
package lbpm_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	localparam int FILE_W = 16;
	localparam int OFF_W  = 24;
	localparam int SIDX_W = 4;
	localparam int RES_W  = 4;
	localparam int TAG_W  = FILE_W + OFF_W;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	// request kinds
	localparam logic [2:0] KIND_LOOKUP   = 3'd0;
	localparam logic [2:0] KIND_ALLOC    = 3'd1;
	localparam logic [2:0] KIND_FREE     = 3'd2;
	localparam logic [2:0] KIND_FREE_ALL = 3'd3;
	localparam logic [2:0] KIND_DROP     = 3'd4;

	// result events
	localparam logic [2:0] EV_HIT       = 3'd0;
	localparam logic [2:0] EV_MISS      = 3'd1;
	localparam logic [2:0] EV_FETCH     = 3'd2;
	localparam logic [2:0] EV_DIRTY_WB  = 3'd3;
	localparam logic [2:0] EV_ZERO_WB   = 3'd4;
	localparam logic [2:0] EV_NO_VICTIM = 3'd5;
	localparam logic [2:0] EV_DONE      = 3'd6;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [SLOT_W-1:0] push_slot;
	} free_ctl_t;

endpackage

FILE: sv/lbpm_tag_ram.sv
// ----------------------------------------------------------------------------
// lbpm_tag_ram
// Simple dual-port tag memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbpm_tag_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 40
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/lbpm_free_fifo.sv
// ----------------------------------------------------------------------------
// lbpm_free_fifo
// Circular queue of free slots, full with all slots in order after reset.
// ----------------------------------------------------------------------------
module lbpm_free_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbpm_pkg::free_ctl_t        ctl,
	output logic [lbpm_pkg::SLOT_W-1:0] head_slot,
	output logic [lbpm_pkg::CNT_W-1:0]  count
);

	logic [lbpm_pkg::SLOT_W-1:0] slot_q [lbpm_pkg::SLOTS];
	logic [lbpm_pkg::SLOT_W-1:0] head_q;
	logic [lbpm_pkg::SLOT_W-1:0] tail_q;
	logic [lbpm_pkg::CNT_W-1:0]  cnt_q;

	assign head_slot = slot_q[head_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lbpm_pkg::SLOTS; i++) begin
				slot_q[i] <= lbpm_pkg::SLOT_W'(i);
			end
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= lbpm_pkg::CNT_W'(lbpm_pkg::SLOTS);
		end else begin
			if (ctl.push) begin
				slot_q[tail_q] <= ctl.push_slot;
				tail_q <= (tail_q == lbpm_pkg::SLOT_W'(lbpm_pkg::SLOTS - 1)) ?
					'0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == lbpm_pkg::SLOT_W'(lbpm_pkg::SLOTS - 1)) ?
					'0 : head_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/lru_buffer_pool_manager_unit.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_manager_unit
// Tag manager for a pool of block frames: recency list, free queue, tags,
// dirty and pin bits; lookup, allocate, free, free all and drop file.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tuser: kind; tdata: file_id, block_offset,
//                                     slot_index
//  m_*      out  m_tvalid / m_tready  tuser: event_res; tdata: result_slot,
//                                     event_file, event_offset; tlast: last
//
//  One request at a time. The recency scan reads the tag memory once per
//  list entry, in a read state followed by a check state. Reset empties
//  the recency list, fills the free queue and clears the dirty and pin
//  bits at once; no clearing pass. A full output register stalls the scan
//  where a result must be issued.
// ----------------------------------------------------------------------------
module lru_buffer_pool_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // file_id[15:0], block_offset[39:16], slot_index[43:40]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // result_slot[3:0], event_file[19:4], event_offset[43:20]
	output logic [2:0]  m_tuser,  // event_res[2:0]
	output logic        m_tlast
);

	localparam int SW = lbpm_pkg::SLOT_W;
	localparam int CW = lbpm_pkg::CNT_W;

	typedef enum logic [2:0] {ST_IDLE, ST_START, ST_RD, ST_CHK, ST_FIN} state_t;
	typedef enum logic [1:0] {REC_NONE, REC_PUSH, REC_REMOVE, REC_TOMRU} rec_op_t;

	state_t state_q, state_d;

	// request registers
	logic [2:0]                    kind_q;
	logic [lbpm_pkg::FILE_W-1:0]   file_q;
	logic [lbpm_pkg::OFF_W-1:0]    off_q;
	logic [lbpm_pkg::SIDX_W-1:0]   sidx_q;
	logic [CW-1:0]                 pos_q, pos_d;
	logic [SW-1:0]                 cur_q, cur_d;
	logic [SW-1:0]                 fin_slot_q, fin_slot_d;
	logic [2:0]                    fin_ev_q, fin_ev_d;
	logic                          clr_rcnt;

	// recency list, oldest first
	logic [SW-1:0] rec_q [lbpm_pkg::SLOTS];
	logic [SW-1:0] rec_d [lbpm_pkg::SLOTS];
	logic [CW-1:0] rcnt_q;
	rec_op_t       rec_op;
	logic [SW-1:0] rec_slot;

	logic [lbpm_pkg::SLOTS-1:0] dirty_q, pin_q;
	logic          dp_we, dp_dirty, dp_pin;
	logic [SW-1:0] dp_slot;

	// output register
	logic                             m_valid_q;
	logic [lbpm_pkg::RES_W-1:0]       m_slot_q;
	logic [2:0]                       m_ev_q;
	logic [lbpm_pkg::FILE_W-1:0]      m_file_q;
	logic [lbpm_pkg::OFF_W-1:0]       m_off_q;
	logic                             m_last_q;
	logic                             emit, e_last;
	logic [SW-1:0]                    e_slot;
	logic [2:0]                       e_ev;
	logic [lbpm_pkg::FILE_W-1:0]      e_file;
	logic [lbpm_pkg::OFF_W-1:0]       e_off;
	logic                             out_free;

	// tag memory and free queue
	logic                        ram_we, ram_re;
	logic [SW-1:0]               ram_raddr;
	logic [lbpm_pkg::TAG_W-1:0]  ram_rdata;
	lbpm_pkg::free_ctl_t         fctl;
	logic [SW-1:0]               free_head;
	logic [CW-1:0]               free_cnt;

	logic [SW-1:0]               pos_idx;
	logic [lbpm_pkg::FILE_W-1:0] tag_file;
	logic [lbpm_pkg::OFF_W-1:0]  tag_off;

	assign pos_idx  = pos_q[SW-1:0];
	assign tag_file = ram_rdata[lbpm_pkg::FILE_W-1:0];
	assign tag_off  = ram_rdata[lbpm_pkg::TAG_W-1:lbpm_pkg::FILE_W];
	assign out_free = !m_valid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_ev_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {4'b0, m_off_q, m_file_q, m_slot_q};

	lbpm_tag_ram #(
		.DEPTH(lbpm_pkg::SLOTS),
		.AW   (SW),
		.DW   (lbpm_pkg::TAG_W)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(rec_slot),
		.wdata({off_q, file_q}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lbpm_free_fifo u_free_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fctl),
		.head_slot(free_head),
		.count    (free_cnt)
	);

	// sequencer: decide the next step, the list edit and any result
	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		cur_d      = cur_q;
		fin_slot_d = fin_slot_q;
		fin_ev_d   = fin_ev_q;
		clr_rcnt   = 1'b0;
		rec_op     = REC_NONE;
		rec_slot   = cur_q;
		dp_we      = 1'b0;
		dp_slot    = cur_q;
		dp_dirty   = 1'b0;
		dp_pin     = 1'b0;
		emit       = 1'b0;
		e_slot     = cur_q;
		e_ev       = lbpm_pkg::EV_ZERO_WB;
		e_file     = tag_file;
		e_off      = tag_off;
		e_last     = 1'b1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = rec_q[pos_idx];
		fctl       = '0;
		fctl.push_slot = cur_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_START;
					pos_d   = '0;
				end
			end
			ST_START: begin
				state_d    = ST_FIN;
				fin_slot_d = '0;
				fin_ev_d   = lbpm_pkg::EV_DONE;
				case (kind_q) inside
					lbpm_pkg::KIND_LOOKUP: begin
						fin_ev_d = lbpm_pkg::EV_MISS;
						if (rcnt_q != '0) state_d = ST_RD;
					end
					lbpm_pkg::KIND_ALLOC: begin
						if (free_cnt != '0) begin
							// take the oldest free slot
							rec_slot   = free_head;
							rec_op     = REC_PUSH;
							ram_we     = 1'b1;
							fctl.pop   = 1'b1;
							dp_we      = 1'b1;
							dp_slot    = free_head;
							dp_pin     = 1'b1;
							fin_slot_d = free_head;
							fin_ev_d   = lbpm_pkg::EV_FETCH;
						end else begin
							fin_ev_d = lbpm_pkg::EV_NO_VICTIM;
							state_d  = ST_RD;
						end
					end
					lbpm_pkg::KIND_FREE: begin
						fin_slot_d = SW'(sidx_q);
						if (rcnt_q != '0) state_d = ST_RD;
					end
					lbpm_pkg::KIND_FREE_ALL, lbpm_pkg::KIND_DROP: begin
						if (rcnt_q != '0) state_d = ST_RD;
					end
					default: ;
				endcase
			end
			ST_RD: begin
				if (pos_q >= rcnt_q) begin
					// scan exhausted: the prepared final result stands
					state_d = ST_FIN;
				end else begin
					ram_re  = 1'b1;
					cur_d   = rec_q[pos_idx];
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = ST_RD;
				pos_d   = pos_q + 1'b1;
				case (kind_q)
					lbpm_pkg::KIND_LOOKUP: begin
						if (tag_file == file_q && tag_off == off_q) begin
							rec_op     = REC_TOMRU;
							dp_we      = 1'b1;
							dp_dirty   = 1'b1;
							fin_slot_d = cur_q;
							fin_ev_d   = lbpm_pkg::EV_HIT;
							state_d    = ST_FIN;
						end
					end
					lbpm_pkg::KIND_ALLOC: begin
						if (!pin_q[cur_q]) begin
							if (dirty_q[cur_q] && !out_free) begin
								state_d = ST_CHK;
								pos_d   = pos_q;
							end else begin
								emit       = dirty_q[cur_q];
								e_ev       = lbpm_pkg::EV_DIRTY_WB;
								e_last     = 1'b0;
								rec_op     = REC_TOMRU;
								ram_we     = 1'b1;
								dp_we      = 1'b1;
								dp_pin     = 1'b1;
								fin_slot_d = cur_q;
								fin_ev_d   = lbpm_pkg::EV_FETCH;
								state_d    = ST_FIN;
							end
						end
					end
					lbpm_pkg::KIND_FREE: begin
						if ((SW + 4)'(cur_q) == (SW + 4)'(sidx_q)) begin
							if (!out_free) begin
								state_d = ST_CHK;
								pos_d   = pos_q;
							end else begin
								emit      = 1'b1;
								rec_op    = REC_REMOVE;
								fctl.push = 1'b1;
								dp_we     = 1'b1;
								state_d   = ST_IDLE;
							end
						end
					end
					lbpm_pkg::KIND_FREE_ALL: begin
						if (!out_free) begin
							state_d = ST_CHK;
							pos_d   = pos_q;
						end else begin
							emit      = 1'b1;
							e_last    = (pos_q + 1'b1 == rcnt_q);
							fctl.push = 1'b1;
							dp_we     = 1'b1;
							if (e_last) begin
								clr_rcnt = 1'b1;
								state_d  = ST_IDLE;
							end
						end
					end
					default: begin
						// drop file: remove a matching entry and hold the position
						if (tag_file == file_q) begin
							rec_op    = REC_REMOVE;
							fctl.push = 1'b1;
							dp_we     = 1'b1;
							pos_d     = pos_q;
						end
					end
				endcase
			end
			ST_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					e_slot  = fin_slot_q;
					e_ev    = fin_ev_q;
					e_file  = file_q;
					e_off   = off_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// recency list edit: append, remove at pos, or move pos to the newest end
	always_comb begin
		for (int j = 0; j < lbpm_pkg::SLOTS; j++) begin
			rec_d[j] = rec_q[j];
			case (rec_op) inside
				REC_PUSH: begin
					if (CW'(j) == rcnt_q) rec_d[j] = rec_slot;
				end
				REC_REMOVE, REC_TOMRU: begin
					if (CW'(j) >= pos_q && j < lbpm_pkg::SLOTS - 1) begin
						rec_d[j] = rec_q[(j + 1) % lbpm_pkg::SLOTS];
					end
					if (rec_op == REC_TOMRU && CW'(j) == rcnt_q - 1'b1) begin
						rec_d[j] = rec_slot;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= '0;
			pos_q      <= '0;
			cur_q      <= '0;
			fin_slot_q <= '0;
			fin_ev_q   <= lbpm_pkg::EV_DONE;
			rcnt_q     <= '0;
			dirty_q    <= '0;
			pin_q      <= '0;
			m_valid_q  <= 1'b0;
			for (int j = 0; j < lbpm_pkg::SLOTS; j++) begin
				rec_q[j] <= '0;
			end
		end else begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			cur_q      <= cur_d;
			fin_slot_q <= fin_slot_d;
			fin_ev_q   <= fin_ev_d;
			rec_q      <= rec_d;
			if (s_tvalid && s_tready) begin
				kind_q <= s_tuser;
			end
			if (clr_rcnt) begin
				rcnt_q <= '0;
			end else if (rec_op == REC_PUSH) begin
				rcnt_q <= rcnt_q + 1'b1;
			end else if (rec_op == REC_REMOVE) begin
				rcnt_q <= rcnt_q - 1'b1;
			end
			if (dp_we) begin
				dirty_q[dp_slot] <= dp_dirty;
				pin_q[dp_slot]   <= dp_pin;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			file_q <= s_tdata[15:0];
			off_q  <= s_tdata[39:16];
			sidx_q <= s_tdata[43:40];
		end
		if (emit) begin
			m_slot_q <= lbpm_pkg::RES_W'(e_slot);
			m_ev_q   <= e_ev;
			m_file_q <= e_file;
			m_off_q  <= e_off;
			m_last_q <= e_last;
		end
	end

	// every slot is either listed or queued free between requests
	a_slot_census: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (rcnt_q + free_cnt) == CW'(lbpm_pkg::SLOTS))
		else $error("slot census broken");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_ev_q == lbpm_pkg::EV_DIRTY_WB |-> !m_last_q)
		else $error("dirty write-back marked last");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= CW'(lbpm_pkg::SLOTS))
		else $error("recency count overflow");

endmodule
